### sv/sitda_pkg.sv
package sitda_pkg;

  localparam int MAG_W         = 64;
  localparam int DIGIT_W       = 4;
  localparam int NUM_DIGITS    = 19;
  localparam int BCD_W         = NUM_DIGITS * DIGIT_W;
  localparam int IDX_W         = 5;
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS    = MAG_W / BITS_PER_STEP;
  localparam int CNT_W         = 4;
  localparam int CHAR_W        = 6;
  localparam int Q_DEPTH       = 2;
  localparam int Q_PTR_W       = 1;
  localparam int Q_CNT_W       = 2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_DONE
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SIGN,
    B_DIGIT
  } back_state_t;

  typedef struct packed {
    logic              neg;
    logic [BCD_W-1:0]  bcd;
    logic [IDX_W-1:0]  top;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b_in,
                                               input logic bit_in);
    logic [BCD_W-1:0] b;
    b = b_in;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (b[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        b[d*DIGIT_W +: DIGIT_W] = b[d*DIGIT_W +: DIGIT_W] + 4'd3;
      end
    end
    return {b[BCD_W-2:0], bit_in};
  endfunction

  function automatic logic [IDX_W-1:0] top_digit(input logic [BCD_W-1:0] b);
    logic [IDX_W-1:0] t;
    t = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (b[d*DIGIT_W +: DIGIT_W] != 4'd0) begin
        t = IDX_W'(d);
      end
    end
    return t;
  endfunction

endpackage

### sv/sitda_front.sv
module sitda_front
  import sitda_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [63:0] in_value,
  input  q_status_t          q_status,
  output logic               q_push,
  output entry_t             q_wr_data
);

  front_state_t      state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [MAG_W-1:0]  mag_r, mag_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  logic              neg_r;
  logic              accept;
  logic              handoff;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_valid) state_nxt = F_CONV;
      end
      F_CONV: begin
        if (cnt_r == CNT_W'(CONV_STEPS - 1)) state_nxt = F_DONE;
      end
      F_DONE: begin
        if (!q_status.full) state_nxt = in_valid ? F_CONV : F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    handoff   = (state_r == F_DONE) && !q_status.full;
    in_stall  = !((state_r == F_IDLE) || handoff);
    accept    = in_valid && !in_stall;
    q_push    = handoff;
    q_wr_data = '{neg: neg_r, bcd: bcd_r, top: top_digit(bcd_r)};
  end

  always_comb begin
    bcd_nxt = bcd_r;
    mag_nxt = mag_r;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      bcd_nxt = dabble(bcd_nxt, mag_nxt[MAG_W-1]);
      mag_nxt = {mag_nxt[MAG_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        cnt_r <= '0;
      end else if (state_r == F_CONV) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg_r <= in_value[MAG_W-1];
      mag_r <= in_value[MAG_W-1] ? (~in_value + 64'd1) : in_value;
      bcd_r <= '0;
    end else if (state_r == F_CONV) begin
      mag_r <= mag_nxt;
      bcd_r <= bcd_nxt;
    end
  end

endmodule

### sv/sitda_fifo.sv
module sitda_fifo
  import sitda_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  entry_t    wr_data,
  input  logic      pop,
  output entry_t    rd_data,
  output q_status_t status
);

  entry_t             mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;

  always_comb begin
    status.full  = (count_r == Q_CNT_W'(Q_DEPTH));
    status.empty = (count_r == '0);
    rd_data      = mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - Q_CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full) else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty) else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH)) else $error("queue count out of range");

endmodule

### sv/sitda_back.sv
module sitda_back
  import sitda_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  entry_t            q_rd_data,
  input  q_status_t         q_status,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_character,
  output logic              out_last
);

  back_state_t         state_r, state_nxt;
  logic [BCD_W-1:0]    bcd_r;
  logic [IDX_W-1:0]    idx_r;
  logic                out_valid_r;
  logic [CHAR_W-1:0]   out_character_r;
  logic                out_last_r;
  logic                adv;
  logic                emit;
  logic                final_digit;
  logic [DIGIT_W-1:0]  digit;
  logic [CHAR_W-1:0]   char_nxt;

  assign adv         = !out_valid_r || !out_stall;
  assign final_digit = (state_r == B_DIGIT) && (idx_r == '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_status.empty) state_nxt = q_rd_data.neg ? B_SIGN : B_DIGIT;
      end
      B_SIGN: begin
        if (adv) state_nxt = B_DIGIT;
      end
      B_DIGIT: begin
        if (adv && idx_r == '0) begin
          if (q_status.empty) begin
            state_nxt = B_IDLE;
          end else begin
            state_nxt = q_rd_data.neg ? B_SIGN : B_DIGIT;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = !q_status.empty && ((state_r == B_IDLE) || (final_digit && adv));
    emit     = adv && ((state_r == B_SIGN) || (state_r == B_DIGIT));
    digit    = bcd_r[{idx_r, 2'b00} +: DIGIT_W];
    char_nxt = (state_r == B_SIGN) ? ASCII_MINUS
                                   : ASCII_ZERO + {{(CHAR_W - DIGIT_W){1'b0}}, digit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      bcd_r <= q_rd_data.bcd;
      idx_r <= q_rd_data.top;
    end else if (state_r == B_DIGIT && adv) begin
      idx_r <= idx_r - IDX_W'(1);
    end
    if (emit) begin
      out_character_r <= char_nxt;
      out_last_r      <= final_digit;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIGIT) |-> (idx_r <= IDX_W'(NUM_DIGITS - 1)))
    else $error("digit index out of range");

  a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && state_r == B_SIGN) |=> (state_r == B_DIGIT))
    else $error("minus sign not followed by digits");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_character_r == ASCII_MINUS) |-> !out_last_r)
    else $error("minus sign flagged as last character");

endmodule

### sv/signed_int_to_decimal_ascii.sv
// Converts a signed 64-bit integer to its decimal text, one ASCII character
// per output item: a minus sign first for negative values, then the digits
// most significant first with no leading zeros, out_last high on the final
// one. The front converts the magnitude in a shift-and-add-3 unit taking
// four bits a cycle, then hands the result to the queue once it is not full;
// in_stall stays high until then, so a new value is taken only while idle
// or at handoff. The back emits one character per cycle while out_stall is
// low; an item has 1 to 20 characters. A two-entry queue between them lets
// both run at once.
module signed_int_to_decimal_ascii
  import sitda_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [63:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         out_character,
  output logic               out_last
);

  q_status_t q_status;
  logic      q_push;
  logic      q_pop;
  entry_t    q_wr_data;
  entry_t    q_rd_data;

  sitda_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_wr_data (q_wr_data)
  );

  sitda_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .status  (q_status)
  );

  sitda_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_rd_data     (q_rd_data),
    .q_status      (q_status),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

### tb/sv/testbench.sv
module testbench;
  import sitda_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } text_char_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [63:0] in_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [5:0]         out_character;
  logic               out_last;

  text_char_t  expected_text[$];
  int unsigned mismatches = 0;
  bit          idling_on = 1'b1;
  bit          hold_req = 1'b0;
  bit          hold_ack = 1'b0;
  int          hold_left = 0;

  signed_int_to_decimal_ascii uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_character(out_character),
    .out_last     (out_last)
  );

  always #4 clk = ~clk;

  function automatic void predict_text(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [3:0]  digits[20];
    int          n;
    text_char_t  c;
    mag = v;
    if (v[63]) begin
      mag = -mag;
      c.character = ASCII_MINUS;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    n = 0;
    do begin
      digits[n] = 4'(mag % 10);
      mag = mag / 10;
      n++;
    end while (mag != 0);
    for (int i = n - 1; i >= 0; i--) begin
      c.character = CHAR_W'(ASCII_ZERO + CHAR_W'(digits[i]));
      c.last = (i == 0);
      expected_text.push_back(c);
    end
  endfunction

  task automatic send_value(input logic signed [63:0] v);
    while (idling_on && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    predict_text(v);
  endtask

  function automatic logic signed [63:0] random_value();
    logic [63:0] v;
    case ($urandom_range(0, 2))
      0: v = {$urandom, $urandom};
      1: v = 64'($urandom_range(0, 999));
      default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    if ($urandom_range(0, 1) == 1) begin
      v = -v;
    end
    return v;
  endfunction

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_ack <= hold_req;
    end else begin
      out_stall <= idling_on && ($urandom_range(0, 99) < 6);
    end
  end

  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected item: character %0d last %0b", $time, out_character,
                 out_last);
        mismatches++;
      end else begin
        want = expected_text.pop_front();
        if (out_character !== want.character) begin
          $display("%0t: character mismatch: expected %0d actual %0d", $time,
                   want.character, out_character);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last mismatch: expected %0b actual %0b", $time, want.last,
                   out_last);
          mismatches++;
        end
      end
    end
  end

  task automatic test_extremes();
    send_value(64'sd0);
    send_value(64'sd1);
    send_value(-64'sd1);
    send_value(64'sd9);
    send_value(64'sd10);
    send_value(-64'sd10);
    send_value(64'sd99);
    send_value(64'sd100);
    send_value(-64'sd909);
    send_value(64'sh7FFF_FFFF_FFFF_FFFF);
    send_value(64'sh8000_0000_0000_0000);
    send_value(64'sh8000_0000_0000_0001);
    send_value(64'sd999999999999999999);
    send_value(64'sd1000000000000000000);
    send_value(-64'sd1000000000000000000);
    send_value(64'sd1234567890123456789);
    send_value(-64'sd9999999999999999);
    send_value(64'sd4294967295);
    send_value(64'sd4294967296);
    send_value(64'shAAAA_AAAA_AAAA_AAAA);
    send_value(64'sh5555_5555_5555_5555);
  endtask

  task automatic test_random_values(input int count);
    for (int i = 0; i < count; i++) begin
      send_value(random_value());
    end
  endtask

  task automatic test_back_to_back(input int count);
    idling_on <= 1'b0;
    for (int i = 0; i < count; i++) begin
      send_value(random_value());
    end
    idling_on <= 1'b1;
  endtask

  task automatic test_output_hold(input int count);
    hold_req <= ~hold_req;
    for (int i = 0; i < count; i++) begin
      send_value(random_value());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_random_values(80);
    test_back_to_back(40);
    test_output_hold(15);
    test_random_values(44);
    in_valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_text.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
